// ===== rtl/smm_pkg.sv =====
package smm_pkg;

    // Fixed field widths
    localparam int SADDR_W = 10;
    localparam int ELEM_W  = 16;
    localparam int OBASE_W = 16;
    localparam int IDX_W   = 17;
    localparam int SUM_W   = 40;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Saturation limits of the result sum
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Command codes
    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0]
    {
        REG_ROW_COUNT   = 3'd0,
        REG_COL_COUNT   = 3'd1,
        REG_INNER_COUNT = 3'd2,
        REG_A_ROW_STEP  = 3'd3,
        REG_A_COL_STEP  = 3'd4,
        REG_B_ROW_STEP  = 3'd5,
        REG_B_COL_STEP  = 3'd6
    } reg_idx_t;

    // Address operands that are reduced modulo the store depth before use
    localparam int NUM_RED   = 7;
    localparam int RED_ADDR  = 0;
    localparam int RED_ABASE = 1;
    localparam int RED_BBASE = 2;
    localparam int RED_ARS   = 3;
    localparam int RED_ACS   = 4;
    localparam int RED_BRS   = 5;
    localparam int RED_BCS   = 6;

endpackage

// ===== rtl/strided_matrix_multiply_top.sv =====
// Strided matrix multiply over a private element store. An item with cmd low
// writes one Q8.8 element and, for a store of 1024 entries or more, is written
// at the edge that accepts it, so writes stream at one per clock. An item with cmd high
// runs the multiply on one shared multiply-accumulate unit fed by a store with
// two registered read ports: rows*cols*max(inner,1) products issue at one per
// cycle, then the pipeline drains; busy stays high for that
// whole time. A start with zero rows or columns finishes at once with no result.
// With a store smaller than 1024 entries, addresses and steps are first reduced
// by repeated subtraction of the depth in a reduce state before launch. Each
// result is shown for exactly one cycle with out_valid high, from a result
// register behind the store read and product registers; the receiver
// cannot stall, so capture it.
module strided_matrix_multiply_top
    import smm_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int MAX_OUTER   = 8,
    parameter int MAX_INNER   = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,

    input  logic                      start,
    output logic                      busy,
    input  logic                      cmd,
    input  logic [SADDR_W-1:0]        store_addr,
    input  logic signed [ELEM_W-1:0]  elem_value,
    input  logic [SADDR_W-1:0]        a_base,
    input  logic [SADDR_W-1:0]        b_base,
    input  logic [OBASE_W-1:0]        out_base,

    output logic                      out_valid,
    output logic [IDX_W-1:0]          out_index,
    output logic signed [SUM_W-1:0]   out_sum,
    output logic                      out_last
);

    localparam int AW      = $clog2(STORE_DEPTH);
    localparam int OW      = $clog2(MAX_OUTER + 1);
    localparam int KW      = $clog2(MAX_INNER + 1);
    localparam int RW      = (AW + 1 > SADDR_W) ? AW + 1 : SADDR_W + 1;
    localparam int ACC_RAW = PROD_W + KW;
    localparam int ACC_W   = (ACC_RAW > SUM_W) ? ACC_RAW : SUM_W;

    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(STORE_DEPTH);
    localparam logic [RW-1:0] DEPTH_R = RW'(STORE_DEPTH);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_REDUCE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Configuration registers
    logic [3:0]         row_count_reg;
    logic [3:0]         col_count_reg;
    logic [6:0]         inner_count_reg;
    logic [SADDR_W-1:0] a_row_step_reg;
    logic [SADDR_W-1:0] a_col_step_reg;
    logic [SADDR_W-1:0] b_row_step_reg;
    logic [SADDR_W-1:0] b_col_step_reg;

    // Sequencer state
    state_t             state_reg;
    cmd_t               cmd_reg;
    logic [SADDR_W-1:0] red_reg [NUM_RED];
    logic [ELEM_W-1:0]  wdata_reg;
    logic [OBASE_W-1:0] obase_reg;
    logic [OW-1:0]      rows_reg;
    logic [OW-1:0]      cols_reg;
    logic [KW-1:0]      inner_reg;
    logic               zero_run_reg;
    logic [OW-1:0]      i_reg;
    logic [OW-1:0]      j_reg;
    logic [KW-1:0]      k_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [AW-1:0]      ars_reg;
    logic [AW-1:0]      acs_reg;
    logic [AW-1:0]      brs_reg;
    logic [AW-1:0]      bcs_reg;
    logic [AW-1:0]      b_base_reg;
    logic [AW-1:0]      a_row_reg;
    logic [AW-1:0]      a_addr_reg;
    logic [AW-1:0]      b_col_reg;
    logic [AW-1:0]      b_addr_reg;

    // Multiply-accumulate pipeline
    logic                     v1_reg;
    logic                     first1_reg;
    logic                     last1_reg;
    logic                     zero1_reg;
    logic                     olast1_reg;
    logic [IDX_W-1:0]         idx1_reg;
    logic signed [ELEM_W-1:0] rd_a_reg;
    logic signed [ELEM_W-1:0] rd_b_reg;
    logic                     v2_reg;
    logic                     first2_reg;
    logic                     last2_reg;
    logic                     olast2_reg;
    logic [IDX_W-1:0]         idx2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_index_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic                     out_last_reg;

    // Element store
    logic [ELEM_W-1:0] store_mem [STORE_DEPTH];

    logic               accept;
    logic               launch;
    cmd_t               l_cmd;
    logic [SADDR_W-1:0] l_val [NUM_RED];
    logic [NUM_RED-1:0] l_over;
    logic               any_over;
    logic [SADDR_W-1:0] red_sub [NUM_RED];
    logic [RW-1:0]      red_diff [NUM_RED];
    logic [ELEM_W-1:0]  l_wdata;
    logic [OBASE_W-1:0] l_obase;
    logic               mem_we;
    logic [OW-1:0]      rows_l;
    logic [OW-1:0]      cols_l;
    logic [KW-1:0]      inner_l;
    logic               k_last;
    logic               j_last;
    logic               i_last;
    logic [AW-1:0]      a_addr_inc;
    logic [AW-1:0]      b_addr_inc;
    logic [AW-1:0]      a_row_inc;
    logic [AW-1:0]      b_col_inc;
    logic [ACC_W-SUM_W:0] acc_upper;
    logic               acc_ovf;
    logic signed [SUM_W-1:0] sat_sum;
    logic               cfg_we;
    reg_idx_t           cfg_idx;

    // Add two in-range addresses modulo the store depth
    function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] x, input logic [AW-1:0] y);
        logic [AW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= DEPTH_A)
        begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= 4'd1;
            col_count_reg   <= 4'd1;
            inner_count_reg <= 7'd1;
            a_row_step_reg  <= '0;
            a_col_step_reg  <= SADDR_W'(1);
            b_row_step_reg  <= SADDR_W'(1);
            b_col_step_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_ROW_COUNT:   row_count_reg   <= pwdata[3:0];
                REG_COL_COUNT:   col_count_reg   <= pwdata[3:0];
                REG_INNER_COUNT: inner_count_reg <= pwdata[6:0];
                REG_A_ROW_STEP:  a_row_step_reg  <= pwdata[SADDR_W-1:0];
                REG_A_COL_STEP:  a_col_step_reg  <= pwdata[SADDR_W-1:0];
                REG_B_ROW_STEP:  b_row_step_reg  <= pwdata[SADDR_W-1:0];
                REG_B_COL_STEP:  b_col_step_reg  <= pwdata[SADDR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ROW_COUNT:   prdata = PDATA_W'(row_count_reg);
            REG_COL_COUNT:   prdata = PDATA_W'(col_count_reg);
            REG_INNER_COUNT: prdata = PDATA_W'(inner_count_reg);
            REG_A_ROW_STEP:  prdata = PDATA_W'(a_row_step_reg);
            REG_A_COL_STEP:  prdata = PDATA_W'(a_col_step_reg);
            REG_B_ROW_STEP:  prdata = PDATA_W'(b_row_step_reg);
            REG_B_COL_STEP:  prdata = PDATA_W'(b_col_step_reg);
            default:         prdata = '0;
        endcase
    end

    // Item handshake
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Pick launch operands: fresh from the ports, or from the reduce stage
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            l_val[RED_ADDR]  = store_addr;
            l_val[RED_ABASE] = a_base;
            l_val[RED_BBASE] = b_base;
            l_val[RED_ARS]   = a_row_step_reg;
            l_val[RED_ACS]   = a_col_step_reg;
            l_val[RED_BRS]   = b_row_step_reg;
            l_val[RED_BCS]   = b_col_step_reg;
            l_cmd            = cmd_t'(cmd);
            l_wdata          = elem_value;
            l_obase          = out_base;
        end
        else
        begin
            l_val   = red_reg;
            l_cmd   = cmd_reg;
            l_wdata = wdata_reg;
            l_obase = obase_reg;
        end
    end

    // Check each operand against the depth and form its reduced value
    always_comb
    begin
        for (int e = 0; e < NUM_RED; e++)
        begin
            l_over[e]   = RW'(l_val[e]) >= DEPTH_R;
            red_diff[e] = RW'(l_val[e]) - DEPTH_R;
            red_sub[e]  = red_diff[e][SADDR_W-1:0];
        end
    end

    assign any_over = |l_over;
    assign launch   = (accept || (state_reg == ST_REDUCE)) && !any_over;
    assign mem_we   = launch && (l_cmd == CMD_WRITE);

    // Clamp the counts
    assign rows_l  = (32'(row_count_reg) > MAX_OUTER) ? OW'(MAX_OUTER) : OW'(row_count_reg);
    assign cols_l  = (32'(col_count_reg) > MAX_OUTER) ? OW'(MAX_OUTER) : OW'(col_count_reg);
    assign inner_l = (32'(inner_count_reg) > MAX_INNER) ? KW'(MAX_INNER) : KW'(inner_count_reg);

    // Loop ends and next addresses
    assign k_last = zero_run_reg || ((k_reg + KW'(1)) == inner_reg);
    assign j_last = (j_reg + OW'(1)) == cols_reg;
    assign i_last = (i_reg + OW'(1)) == rows_reg;

    assign a_addr_inc = mod_add(a_addr_reg, acs_reg);
    assign b_addr_inc = mod_add(b_addr_reg, brs_reg);
    assign a_row_inc  = mod_add(a_row_reg, ars_reg);
    assign b_col_inc  = mod_add(b_col_reg, bcs_reg);

    // Accumulate and saturate to the result width
    assign acc_next  = (first2_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
    assign acc_upper = acc_next[ACC_W-1:SUM_W-1];
    assign acc_ovf   = !((&acc_upper) || !(|acc_upper));
    assign sat_sum   = acc_ovf ? (acc_next[ACC_W-1] ? SUM_MIN : SUM_MAX)
                               : acc_next[SUM_W-1:0];

    // Sequencer and registered strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= (state_reg == ST_RUN);
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg && last2_reg;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && any_over)
                    begin
                        state_reg <= ST_REDUCE;
                    end
                end
                ST_REDUCE:
                begin
                end
                ST_RUN:
                begin
                    if (k_last && j_last && i_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Launch: a write finishes at once, a multiply with work starts running
            if (launch)
            begin
                if ((l_cmd == CMD_START) && (rows_l != '0) && (cols_l != '0))
                begin
                    state_reg <= ST_RUN;
                end
                else
                begin
                    state_reg <= ST_IDLE;
                end
            end
        end
    end

    // Sequencer payload: operands, counters and addresses
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(cmd);
            wdata_reg <= elem_value;
            obase_reg <= out_base;
        end

        // Hold or reduce operands by one depth per cycle
        if (accept && any_over)
        begin
            red_reg <= l_val;
        end
        else if (state_reg == ST_REDUCE)
        begin
            for (int e = 0; e < NUM_RED; e++)
            begin
                if (l_over[e])
                begin
                    red_reg[e] <= red_sub[e];
                end
            end
        end

        if (launch)
        begin
            rows_reg     <= rows_l;
            cols_reg     <= cols_l;
            inner_reg    <= inner_l;
            zero_run_reg <= (inner_l == '0);
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            idx_reg      <= IDX_W'(l_obase);
            ars_reg      <= AW'(l_val[RED_ARS]);
            acs_reg      <= AW'(l_val[RED_ACS]);
            brs_reg      <= AW'(l_val[RED_BRS]);
            bcs_reg      <= AW'(l_val[RED_BCS]);
            b_base_reg   <= AW'(l_val[RED_BBASE]);
            a_row_reg    <= AW'(l_val[RED_ABASE]);
            a_addr_reg   <= AW'(l_val[RED_ABASE]);
            b_col_reg    <= AW'(l_val[RED_BBASE]);
            b_addr_reg   <= AW'(l_val[RED_BBASE]);
        end
        else if (state_reg == ST_RUN)
        begin
            // Tag the product issued this cycle
            first1_reg <= (k_reg == '0);
            last1_reg  <= k_last;
            zero1_reg  <= zero_run_reg;
            olast1_reg <= i_last && j_last;
            idx1_reg   <= idx_reg;

            // Advance inner, then column, then row
            if (!k_last)
            begin
                k_reg      <= k_reg + KW'(1);
                a_addr_reg <= a_addr_inc;
                b_addr_reg <= b_addr_inc;
            end
            else
            begin
                k_reg   <= '0;
                idx_reg <= idx_reg + IDX_W'(1);
                if (!j_last)
                begin
                    j_reg      <= j_reg + OW'(1);
                    b_col_reg  <= b_col_inc;
                    b_addr_reg <= b_col_inc;
                    a_addr_reg <= a_row_reg;
                end
                else
                begin
                    j_reg      <= '0;
                    b_col_reg  <= b_base_reg;
                    b_addr_reg <= b_base_reg;
                    i_reg      <= i_reg + OW'(1);
                    a_row_reg  <= a_row_inc;
                    a_addr_reg <= a_row_inc;
                end
            end
        end

        // Multiply stage
        prod_reg   <= zero1_reg ? PROD_W'(0) : PROD_W'(rd_a_reg * rd_b_reg);
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        olast2_reg <= olast1_reg;
        idx2_reg   <= idx1_reg;

        // Accumulate stage and result register
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (v2_reg && last2_reg)
        begin
            out_sum_reg   <= sat_sum;
            out_index_reg <= idx2_reg;
            out_last_reg  <= olast2_reg;
        end
    end

    // Element store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[AW'(l_val[RED_ADDR])] <= l_wdata;
        end
        rd_a_reg <= store_mem[a_addr_reg];
        rd_b_reg <= store_mem[b_addr_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_sum   = out_sum_reg;
    assign out_last  = out_last_reg;

endmodule
